/* hdl/tkk_pkg.sv */
// ============================================================================
// tkk_pkg
// Shared widths, the slot entry type and defaults for the top-k score keeper.
// ============================================================================
package tkk_pkg;

    // Field widths of one item.
    localparam int OP_W    = 2;
    localparam int SIZE_W  = 5;
    localparam int KEY_W   = 32;
    localparam int LABEL_W = 32;
    localparam int SCORE_W = 24;

    // The tracked minimum carries one extra bit so that all ones means none.
    localparam int LOWEST_W = SCORE_W + 1;

    // Default number of slots in the table.
    localparam int SLOTS_DEFAULT = 16;

    // Operation codes of one item.
    typedef enum logic [OP_W-1:0] {
        OP_OPEN  = 2'd0,
        OP_OFFER = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } tkk_op_t;

    // One slot of the table as it sits in the slot memory.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [LABEL_W-1:0] label;
        logic [SCORE_W-1:0] score;
    } tkk_entry_t;

endpackage

/* hdl/top_k_score_keeper_core.sv */
// ============================================================================
// top_k_score_keeper_core
// Keeps the best-scoring candidates in a slot memory; offers, rescans, sorts
// and ranked reads are run by one sequencer over the memory's single ports.
// ============================================================================
// Open, no-op and ignored items and an offer into a free slot finish in S_EXEC;
// an offer replacing the minimum rescans all slots, reading one slot a cycle; a read
// of an unsorted table sorts the filled region when it holds more than one entry,
// then rescans for the minimum, set by the single read port; a sorted read fetches directly.
// The next item is accepted at the edge that takes done; results are never held off.
// Reset clears control state only; no clearing pass, stale slots are never read.
module top_k_score_keeper_core #(
    parameter int SLOTS = tkk_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tkk_pkg::OP_W-1:0]    op,
    input  logic [tkk_pkg::SIZE_W-1:0]  table_size,
    input  logic [tkk_pkg::KEY_W-1:0]   key,
    input  logic [tkk_pkg::LABEL_W-1:0] label,
    input  logic [tkk_pkg::SCORE_W-1:0] score,
    input  logic [tkk_pkg::SIZE_W-1:0]  rank,
    output logic                        done,
    output logic                        found,
    output logic [tkk_pkg::KEY_W-1:0]   out_key,
    output logic [tkk_pkg::LABEL_W-1:0] out_label,
    output logic [tkk_pkg::SCORE_W-1:0] out_score
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW = $clog2(SLOTS + 1);
    localparam int LW = tkk_pkg::LOWEST_W;

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_EXEC       = 7'b0000010,
        S_SCAN       = 7'b0000100,
        S_SORT_GRAB  = 7'b0001000,
        S_SORT_CMP   = 7'b0010000,
        S_SORT_STORE = 7'b0100000,
        S_READOUT    = 7'b1000000
    } tkk_state_t;

    tkk_state_t state_reg, state_next;

    // Latched item.
    logic [tkk_pkg::OP_W-1:0]    cmd_op_reg;
    logic [tkk_pkg::SIZE_W-1:0]  cmd_size_reg;
    logic [tkk_pkg::SIZE_W-1:0]  cmd_rank_reg;
    tkk_pkg::tkk_entry_t         cmd_entry_reg;

    // Table state.
    logic [SW-1:0] size_reg, size_next;
    logic [SW-1:0] empty_reg, empty_next;
    logic [LW-1:0] lowest_score_reg, lowest_score_next;
    logic [AW-1:0] lowest_slot_reg, lowest_slot_next;
    logic          sorted_reg, sorted_next;

    // Scan and sort sequencing.
    logic [SW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [SW-1:0] pidx_reg, pidx_next;
    logic [LW-1:0] run_score_reg, run_score_next;
    logic [AW-1:0] run_slot_reg, run_slot_next;
    logic          scan_rd_reg, scan_rd_next;
    logic [SW-1:0] i_reg, i_next;
    logic [SW-1:0] j_reg, j_next;
    tkk_pkg::tkk_entry_t cur_reg, cur_next;

    // Result register.
    logic                        done_reg, done_next;
    logic                        found_reg, found_next;
    tkk_pkg::tkk_entry_t         res_reg, res_next;

    // Memory ports.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    tkk_pkg::tkk_entry_t ram_wdata;
    logic [AW-1:0]       ram_raddr;
    tkk_pkg::tkk_entry_t ram_rdata;

    logic [SW-1:0] filled;
    logic [AW-1:0] fetch_addr;
    logic          read_ok;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign found     = found_reg;
    assign out_key   = res_reg.key;
    assign out_label = res_reg.label;
    assign out_score = res_reg.score;

    // Filled region is slots empty .. size-1.
    assign filled     = size_reg - empty_reg;
    assign fetch_addr = AW'(32'(empty_reg) + 32'(cmd_rank_reg) - 32'd1);
    assign read_ok    = (size_reg != '0) && (cmd_rank_reg != '0)
                        && (32'(cmd_rank_reg) <= 32'(filled));

    tkk_slot_ram #(
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Item latch.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_op_reg          <= op;
            cmd_size_reg        <= table_size;
            cmd_rank_reg        <= rank;
            cmd_entry_reg.key   <= key;
            cmd_entry_reg.label <= label;
            cmd_entry_reg.score <= score;
        end
    end

    // Sequencer.
    always_comb
    begin
        logic [LW-1:0]       rs;
        logic [AW-1:0]       rsl;
        tkk_pkg::tkk_entry_t c;

        rs  = run_score_reg;
        rsl = run_slot_reg;
        c   = cur_reg;

        state_next        = state_reg;
        size_next         = size_reg;
        empty_next        = empty_reg;
        lowest_score_next = lowest_score_reg;
        lowest_slot_next  = lowest_slot_reg;
        sorted_next       = sorted_reg;
        idx_next          = idx_reg;
        pend_next         = pend_reg;
        pidx_next         = pidx_reg;
        run_score_next    = run_score_reg;
        run_slot_next     = run_slot_reg;
        scan_rd_next      = scan_rd_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        cur_next          = cur_reg;
        done_next         = 1'b0;
        found_next        = 1'b0;
        res_next          = res_reg;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = cmd_entry_reg;
        ram_raddr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // Most paths finish here with an all-zero result.
                state_next = S_IDLE;
                done_next  = 1'b1;
                found_next = 1'b0;
                res_next   = '0;
                case (cmd_op_reg)
                    tkk_pkg::OP_OPEN:
                    begin
                        if (cmd_size_reg != '0)
                        begin
                            if (32'(cmd_size_reg) > 32'(SLOTS))
                            begin
                                size_next = SW'(SLOTS);
                            end
                            else
                            begin
                                size_next = SW'(cmd_size_reg);
                            end
                            empty_next        = size_next;
                            lowest_score_next = '1;
                            lowest_slot_next  = '0;
                            sorted_next       = 1'b0;
                        end
                    end

                    tkk_pkg::OP_OFFER:
                    begin
                        if (size_reg != '0)
                        begin
                            sorted_next = 1'b0;
                            if (empty_reg != '0)
                            begin
                                // Fill the next free slot from the top down.
                                empty_next = empty_reg - SW'(1);
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(empty_next);
                                if ({1'b0, cmd_entry_reg.score} < lowest_score_reg)
                                begin
                                    lowest_score_next = {1'b0, cmd_entry_reg.score};
                                    lowest_slot_next  = AW'(empty_next);
                                end
                            end
                            else if ({1'b0, cmd_entry_reg.score} > lowest_score_reg)
                            begin
                                // Replace the minimum, then rescan all slots.
                                ram_we         = 1'b1;
                                ram_waddr      = lowest_slot_reg;
                                idx_next       = '0;
                                pend_next      = 1'b0;
                                run_score_next = {1'b0, cmd_entry_reg.score};
                                run_slot_next  = lowest_slot_reg;
                                scan_rd_next   = 1'b0;
                                done_next      = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                    end

                    tkk_pkg::OP_READ:
                    begin
                        if (read_ok)
                        begin
                            done_next = 1'b0;
                            if (sorted_reg)
                            begin
                                ram_raddr  = fetch_addr;
                                state_next = S_READOUT;
                            end
                            else
                            begin
                                sorted_next = (empty_reg == '0);
                                if (filled > SW'(1))
                                begin
                                    i_next     = SW'(1);
                                    ram_raddr  = AW'(empty_reg + SW'(1));
                                    state_next = S_SORT_GRAB;
                                end
                                else
                                begin
                                    idx_next       = empty_reg;
                                    pend_next      = 1'b0;
                                    run_score_next = '1;
                                    run_slot_next  = AW'(empty_reg);
                                    scan_rd_next   = 1'b1;
                                    state_next     = S_SCAN;
                                end
                            end
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // Running minimum over the data read back in the last cycle.
                if (pend_reg && ({1'b0, ram_rdata.score} < rs))
                begin
                    rs  = {1'b0, ram_rdata.score};
                    rsl = AW'(pidx_reg);
                end
                run_score_next = rs;
                run_slot_next  = rsl;
                if (idx_reg < size_reg)
                begin
                    ram_raddr = AW'(idx_reg);
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + SW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if ((idx_reg == size_reg) && pend_reg)
                begin
                    lowest_slot_next = rsl;
                    if (scan_rd_reg)
                    begin
                        ram_raddr  = fetch_addr;
                        state_next = S_READOUT;
                    end
                    else
                    begin
                        lowest_score_next = rs;
                        done_next         = 1'b1;
                        found_next        = 1'b0;
                        res_next          = '0;
                        state_next        = S_IDLE;
                    end
                end
            end

            S_SORT_GRAB:
            begin
                // Hold slot i and start comparing it with the slots before it.
                cur_next   = ram_rdata;
                ram_raddr  = AW'(empty_reg);
                pidx_next  = '0;
                j_next     = SW'(1);
                pend_next  = 1'b1;
                state_next = S_SORT_CMP;
            end

            S_SORT_CMP:
            begin
                // A higher held entry swaps into slot j and carries slot j on.
                if (pend_reg && (cur_reg.score > ram_rdata.score))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(empty_reg + pidx_reg);
                    ram_wdata = cur_reg;
                    c         = ram_rdata;
                end
                cur_next = c;
                if (j_reg < i_reg)
                begin
                    ram_raddr = AW'(empty_reg + j_reg);
                    pidx_next = j_reg;
                    j_next    = j_reg + SW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_SORT_STORE;
                end
            end

            S_SORT_STORE:
            begin
                // Held entry lands in slot i; go on to the next i or find the minimum.
                ram_we    = 1'b1;
                ram_waddr = AW'(empty_reg + i_reg);
                ram_wdata = cur_reg;
                if (SW'(i_reg + SW'(1)) < filled)
                begin
                    i_next     = i_reg + SW'(1);
                    ram_raddr  = AW'(empty_reg + i_next);
                    state_next = S_SORT_GRAB;
                end
                else
                begin
                    idx_next       = empty_reg;
                    pend_next      = 1'b0;
                    run_score_next = '1;
                    run_slot_next  = AW'(empty_reg);
                    scan_rd_next   = 1'b1;
                    state_next     = S_SCAN;
                end
            end

            S_READOUT:
            begin
                done_next  = 1'b1;
                found_next = 1'b1;
                res_next   = ram_rdata;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            size_reg         <= '0;
            empty_reg        <= '0;
            lowest_score_reg <= '1;
            lowest_slot_reg  <= '0;
            sorted_reg       <= 1'b0;
            pend_reg         <= 1'b0;
            scan_rd_reg      <= 1'b0;
            done_reg         <= 1'b0;
            found_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            size_reg         <= size_next;
            empty_reg        <= empty_next;
            lowest_score_reg <= lowest_score_next;
            lowest_slot_reg  <= lowest_slot_next;
            sorted_reg       <= sorted_next;
            pend_reg         <= pend_next;
            scan_rd_reg      <= scan_rd_next;
            done_reg         <= done_next;
            found_reg        <= found_next;
        end
    end

    // Sequencing and result payload.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pidx_reg      <= pidx_next;
        run_score_reg <= run_score_next;
        run_slot_reg  <= run_slot_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        cur_reg       <= cur_next;
        res_reg       <= res_next;
    end

    // A result strobe only comes once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // A table marked sorted has every used slot filled.
    a_sorted_full: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_reg |-> (empty_reg == '0))
        else $error("sorted flag set on a partly filled table");

    // The minimum pointer stays inside the open table.
    a_lowest_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (size_reg != '0) |-> (32'(lowest_slot_reg) < 32'(size_reg)))
        else $error("minimum slot outside the table");

    // Only a read returns a found entry, and only with its strobe.
    a_found_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> done)
        else $error("found without a result strobe");

endmodule

/* hdl/tkk_slot_ram.sv */
// ============================================================================
// tkk_slot_ram
// Slot memory: one write port and one read port, read data registered.
// ============================================================================
module tkk_slot_ram #(
    parameter int DEPTH = tkk_pkg::SLOTS_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  tkk_pkg::tkk_entry_t wdata,
    input  logic [AW-1:0]      raddr,
    output tkk_pkg::tkk_entry_t rdata
);

    tkk_pkg::tkk_entry_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* verif/tb_top_k_score_keeper_core.sv */
// ----------------------------------------------------------------------------
// tb_top_k_score_keeper_core
// Self-checking bench for the top-k score keeper: items are sent over the
// start/busy handshake, every item is run through a local copy of the score
// table, and each done strobe is checked field by field against the oldest
// expected entry. Directed cases come first, then random table sessions under
// several sender idle levels.
// ----------------------------------------------------------------------------
module tb_top_k_score_keeper_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tkk_pkg::*;

    localparam int SLOTS          = SLOTS_DEFAULT;
    localparam int MAX_GAP        = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 200;

    typedef struct packed {
        tkk_op_t             op;
        logic [SIZE_W-1:0]   table_size;
        logic [KEY_W-1:0]    key;
        logic [LABEL_W-1:0]  label;
        logic [SCORE_W-1:0]  score;
        logic [SIZE_W-1:0]   rank;
    } score_cmd_t;

    typedef struct packed {
        logic                found;
        logic [KEY_W-1:0]    key;
        logic [LABEL_W-1:0]  label;
        logic [SCORE_W-1:0]  score;
    } ranked_entry_t;

    // Block ports.
    logic                clk;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     op         = '0;
    logic [SIZE_W-1:0]   table_size = '0;
    logic [KEY_W-1:0]    key        = '0;
    logic [LABEL_W-1:0]  label      = '0;
    logic [SCORE_W-1:0]  score      = '0;
    logic [SIZE_W-1:0]   rank       = '0;
    logic                done;
    logic                found;
    logic [KEY_W-1:0]    out_key;
    logic [LABEL_W-1:0]  out_label;
    logic [SCORE_W-1:0]  out_score;

    // Local copy of the score table.
    tkk_entry_t          tbl [SLOTS];
    logic [SIZE_W-1:0]   tbl_size;
    logic [SIZE_W-1:0]   tbl_empty;
    logic [LOWEST_W-1:0] tbl_lowest;
    logic [3:0]          tbl_lowest_slot;
    logic                tbl_sorted;

    ranked_entry_t       awaited_entries [$];
    int                  idle_pct        = 0;
    int                  err_count       = 0;
    int                  items_sent      = 0;
    int                  results_checked = 0;
    int                  entries_found   = 0;
    int                  stall_cycles    = 0;

    top_k_score_keeper_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .table_size (table_size),
        .key        (key),
        .label      (label),
        .score      (score),
        .rank       (rank),
        .done       (done),
        .found      (found),
        .out_key    (out_key),
        .out_label  (out_label),
        .out_score  (out_score)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Clears the local table to the state with no table open.
    function automatic void table_reset();
        for (int i = 0; i < SLOTS; i++)
            tbl[i] = '0;
        tbl_size        = '0;
        tbl_empty       = '0;
        tbl_lowest      = '1;
        tbl_lowest_slot = '0;
        tbl_sorted      = 1'b0;
    endfunction

    // Applies one item to the local table and returns the entry it yields.
    function automatic ranked_entry_t score_table_step(input score_cmd_t c);
        ranked_entry_t     r;
        logic [SIZE_W-1:0] sz;
        logic [3:0]        s;
        tkk_entry_t        t;
        int                filled;
        int                base;
        int                best;
        int                pos;
        r = '0;
        case (c.op)
            OP_OPEN:
            begin
                if (c.table_size != 0)
                begin
                    sz = (c.table_size > SLOTS) ? SIZE_W'(SLOTS) : c.table_size;
                    table_reset();
                    tbl_size  = sz;
                    tbl_empty = sz;
                end
            end
            OP_OFFER:
            begin
                if (tbl_size != 0)
                begin
                    tbl_sorted = 1'b0;
                    if (tbl_empty > 0)
                    begin
                        // Fill from the top of the used region downward.
                        tbl_empty = tbl_empty - SIZE_W'(1);
                        s = tbl_empty[3:0];
                        tbl[s] = '{c.key, c.label, c.score};
                        if ({1'b0, c.score} < tbl_lowest)
                        begin
                            tbl_lowest      = {1'b0, c.score};
                            tbl_lowest_slot = s;
                        end
                    end
                    else if ({1'b0, c.score} > tbl_lowest)
                    begin
                        // Replace the minimum, then rescan for the new one.
                        tbl[tbl_lowest_slot] = '{c.key, c.label, c.score};
                        tbl_lowest = {1'b0, c.score};
                        for (int i = 0; i < tbl_size; i++)
                        begin
                            if ({1'b0, tbl[i].score} < tbl_lowest)
                            begin
                                tbl_lowest      = {1'b0, tbl[i].score};
                                tbl_lowest_slot = i[3:0];
                            end
                        end
                    end
                end
            end
            OP_READ:
            begin
                filled = int'(tbl_size) - int'(tbl_empty);
                if (tbl_size != 0 && c.rank != 0 && int'(c.rank) <= filled)
                begin
                    base = int'(tbl_empty);
                    if (!tbl_sorted)
                    begin
                        // Exchange sort of the filled region, highest first.
                        for (int i = 1; i < filled; i++)
                        begin
                            for (int j = 0; j < i; j++)
                            begin
                                if (tbl[base + i].score > tbl[base + j].score)
                                begin
                                    t              = tbl[base + i];
                                    tbl[base + i]  = tbl[base + j];
                                    tbl[base + j]  = t;
                                end
                            end
                        end
                        best = base;
                        for (int i = base + 1; i < tbl_size; i++)
                            if (tbl[i].score < tbl[best].score)
                                best = i;
                        tbl_lowest_slot = best[3:0];
                        if (tbl_empty == 0)
                            tbl_sorted = 1'b1;
                    end
                    pos     = base + int'(c.rank) - 1;
                    r.found = 1'b1;
                    r.key   = tbl[pos].key;
                    r.label = tbl[pos].label;
                    r.score = tbl[pos].score;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Item builders; fields the operation does not use are random.
    function automatic score_cmd_t random_cmd();
        score_cmd_t c;
        c.op         = tkk_op_t'(OP_W'($urandom_range(3)));
        c.table_size = SIZE_W'($urandom);
        c.key        = $urandom;
        c.label      = $urandom;
        c.score      = SCORE_W'($urandom);
        c.rank       = SIZE_W'($urandom);
        return c;
    endfunction

    function automatic score_cmd_t mk_open(input int sz);
        score_cmd_t c;
        c            = random_cmd();
        c.op         = OP_OPEN;
        c.table_size = sz[SIZE_W-1:0];
        return c;
    endfunction

    function automatic score_cmd_t mk_offer(input logic [KEY_W-1:0] k,
                                            input logic [LABEL_W-1:0] l,
                                            input logic [SCORE_W-1:0] s);
        score_cmd_t c;
        c       = random_cmd();
        c.op    = OP_OFFER;
        c.key   = k;
        c.label = l;
        c.score = s;
        return c;
    endfunction

    function automatic score_cmd_t mk_read(input int rk);
        score_cmd_t c;
        c      = random_cmd();
        c.op   = OP_READ;
        c.rank = rk[SIZE_W-1:0];
        return c;
    endfunction

    // Score mix: many small values so that ties are common, some extremes.
    function automatic logic [SCORE_W-1:0] pick_score();
        int p;
        p = $urandom_range(99);
        if (p < 40)
            return SCORE_W'($urandom_range(15));
        else if (p < 45)
            return '0;
        else if (p < 50)
            return '1;
        else
            return SCORE_W'($urandom);
    endfunction

    // Sends one item: optional idle gap, then hold start until accepted.
    task automatic send_item(input score_cmd_t c);
        int gap;
        gap = 0;
        while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            gap++;
        end
        start      <= 1'b1;
        op         <= c.op;
        table_size <= c.table_size;
        key        <= c.key;
        label      <= c.label;
        score      <= c.score;
        rank       <= c.rank;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        awaited_entries.push_back(score_table_step(c));
        items_sent++;
    endtask

    // Holds the sender off until every expected entry has come back.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (awaited_entries.size() != 0)
            @(posedge clk);
    endtask

    // Offers, reads and a random item while no table is open, and an open of size zero.
    task automatic test_no_table();
        send_item(mk_offer(32'h1234_5678, 32'h9abc_def0, 24'h00_0100));
        send_item(mk_read(1));
        send_item(random_cmd());
        send_item(mk_open(0));
    endtask

    // A no-op, oversized open, extreme field values, rank zero and rank beyond fill.
    task automatic test_field_extremes();
        score_cmd_t c;
        c    = random_cmd();
        c.op = OP_NOP;
        send_item(c);
        send_item(mk_open(31));
        send_item(mk_offer('1, '1, '1));
        send_item(mk_offer('0, '0, '0));
        send_item(mk_read(0));
        send_item(mk_read(3));
        send_item(mk_read(1));
        send_item(mk_read(2));
    endtask

    // Partial-table read, ties, dropped offers, replacement and sorted reads.
    task automatic test_fill_replace_and_rank();
        send_item(mk_open(3));
        send_item(mk_offer(32'hA0A0_0001, 32'h1111_0001, 24'd100));
        send_item(mk_offer(32'hA0A0_0002, 32'h1111_0002, 24'hFF_FFFF));
        send_item(mk_read(1));
        send_item(mk_offer(32'hA0A0_0003, 32'h1111_0003, 24'd100));
        send_item(mk_offer(32'hA0A0_0004, 32'h1111_0004, 24'd50));
        send_item(mk_offer(32'hA0A0_0005, 32'h1111_0005, 24'd100));
        send_item(mk_offer(32'hA0A0_0006, 32'h1111_0006, 24'd200));
        send_item(mk_read(1));
        send_item(mk_read(3));
        send_item(mk_read(2));
        send_item(mk_read(4));
        wait_for_drain();
    endtask

    // Random table sessions: open, a run of offers and reads, some noise.
    task automatic test_random_traffic(input int target, input int pct);
        int n0;
        int sz;
        int used;
        int n_ops;
        int p;
        idle_pct = pct;
        n0       = items_sent;
        while (items_sent - n0 < target)
        begin
            p = $urandom_range(99);
            if (p < 10)
            begin
                repeat ($urandom_range(1, 3))
                    send_item(random_cmd());
            end
            else
            begin
                p    = $urandom_range(99);
                sz   = (p < 8) ? SLOTS : (p < 12) ? $urandom_range(17, 31)
                                                  : $urandom_range(1, 6);
                used = (sz > SLOTS) ? SLOTS : sz;
                send_item(mk_open(sz));
                n_ops = $urandom_range(used + 2, 2 * used + 6);
                for (int k = 0; k < n_ops; k++)
                begin
                    p = $urandom_range(99);
                    if (p < 60)
                        send_item(mk_offer($urandom, $urandom, pick_score()));
                    else if (p < 92)
                        send_item(mk_read($urandom_range(1, used)));
                    else
                        send_item(random_cmd());
                end
            end
        end
    endtask

    // Result checker: every done strobe against the oldest expected entry.
    always @(posedge clk)
    begin : check_result
        ranked_entry_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (awaited_entries.size() == 0)
            begin
                report_mismatch($sformatf("result with no item pending: found=%b key=%h",
                                          found, out_key));
            end
            else
            begin
                exp_r = awaited_entries.pop_front();
                results_checked++;
                if (exp_r.found)
                    entries_found++;
                if (found !== exp_r.found)
                    report_mismatch($sformatf("found: expected %b got %b",
                                              exp_r.found, found));
                if (out_key !== exp_r.key)
                    report_mismatch($sformatf("out_key: expected %h got %h",
                                              exp_r.key, out_key));
                if (out_label !== exp_r.label)
                    report_mismatch($sformatf("out_label: expected %h got %h",
                                              exp_r.label, out_label));
                if (out_score !== exp_r.score)
                    report_mismatch($sformatf("out_score: expected %h got %h",
                                              exp_r.score, out_score));
            end
        end
    end

    // Watchdog: ends the run when no item is accepted or finished for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no item moved for %0d cycles",
                         $realtime, stall_cycles);
                $display("** top_k_score_keeper_core: FAILED **");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        table_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 0;
        test_no_table();
        test_field_extremes();
        test_fill_replace_and_rank();

        test_random_traffic(250, 0);
        test_random_traffic(250, 71);
        wait_for_drain();
        test_random_traffic(250, 29);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_entries.size() != 0)
            report_mismatch($sformatf("%0d expected entries never arrived",
                                      awaited_entries.size()));

        $display("Run covered %0d items and %0d checked results; %0d reads returned an entry.",
                 items_sent, results_checked, entries_found);
        $display("Sender idle levels of 0, 71 and 29 percent; %0d mismatches.", err_count);
        if (err_count == 0)
            $display("** top_k_score_keeper_core: PASSED **");
        else
            $display("** top_k_score_keeper_core: FAILED **");
        $finish;
    end

endmodule
